// ===== rtl/core/uvs_pkg.sv =====
`default_nettype none

package uvs_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int COUNT_BITS   = 8;
  localparam int FIELD_BITS   = 8;
  localparam int CORDIC_STEPS = 28;
  localparam int TEX_FRAC     = 16;
  localparam int TEX_W        = TEX_FRAC + 1;
  localparam int QUO_W        = (ANGLE_BITS + 1 > TEX_W) ? ANGLE_BITS + 1 : TEX_W;
  localparam int NUM_W        = FIELD_BITS + QUO_W;
  localparam int DEN_W        = COUNT_BITS + 1;
  localparam int XY_W         = 34;
  localparam int Z_W          = 34;
  localparam int TURN_W       = 32;

  localparam int DIV_LANES = 4;
  localparam int LANE_U    = 0;
  localparam int LANE_V    = 1;
  localparam int LANE_LON  = 2;
  localparam int LANE_LAT  = 3;

  localparam int CORD_LANES = 2;
  localparam int CL_LAT     = 0;
  localparam int CL_LON     = 1;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_STACK_COUNT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_COUNT = CFG_IDX_W'(1);

  localparam logic [FIELD_BITS-1:0] STACK_COUNT_RST  = FIELD_BITS'(18);
  localparam logic [FIELD_BITS-1:0] SECTOR_COUNT_RST = FIELD_BITS'(36);

  localparam logic [XY_W-1:0] CORDIC_GAIN = XY_W'(32'h26DD3B6A);

  localparam logic [TURN_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005
  };

  typedef struct packed {
    logic [FIELD_BITS-1:0] stack_index;
    logic [FIELD_BITS-1:0] sector_index;
  } in_t;

  typedef struct packed {
    logic              point_valid;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [TEX_W-1:0]  tex_u;
    logic [TEX_W-1:0]  tex_v;
    logic [15:0]       vertex_index;
    logic [15:0]       below_index;
    logic              upper_tri_valid;
    logic              lower_tri_valid;
  } out_t;

  typedef struct packed {
    logic                  pv;
    logic                  up;
    logic                  lo;
    logic [15:0]           vidx;
    logic [COUNT_BITS-1:0] nc;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
  } ctx_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic              flip;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cord_lane_t;

  function automatic logic [COUNT_BITS-1:0] eff_count(input logic [FIELD_BITS-1:0] r);
    logic [COUNT_BITS-1:0] c;
    c = r[COUNT_BITS-1:0];
    return (c == '0) ? COUNT_BITS'(1) : c;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) begin
      return 16'h7FFF;
    end else if (v < -64'sd32768) begin
      return 16'h8000;
    end
    return v[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/uvs_div.sv =====
`default_nettype none

module uvs_div (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     en,
  input  wire logic                                     in_valid,
  input  wire uvs_pkg::side_t                           in_side,
  input  wire uvs_pkg::div_lane_t [uvs_pkg::DIV_LANES-1:0] in_lanes,
  output logic                                          out_valid,
  output uvs_pkg::side_t                                out_side,
  output uvs_pkg::div_lane_t [uvs_pkg::DIV_LANES-1:0]   out_lanes
);
  import uvs_pkg::*;

  logic                             valid_r [QUO_W];
  side_t                            side_r  [QUO_W];
  div_lane_t [DIV_LANES-1:0]        lane_r  [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int K = QUO_W - 1 - s;
    logic                      v_in;
    side_t                     sd_in;
    div_lane_t [DIV_LANES-1:0] ln_in;
    div_lane_t [DIV_LANES-1:0] lane_nxt;
    logic [NUM_W:0]            trial;

    if (s == 0) begin : g_first
      assign v_in  = in_valid;
      assign sd_in = in_side;
      assign ln_in = in_lanes;
    end else begin : g_next
      assign v_in  = valid_r[s-1];
      assign sd_in = side_r[s-1];
      assign ln_in = lane_r[s-1];
    end

    always_comb begin
      lane_nxt = ln_in;
      trial    = '0;
      for (int l = 0; l < DIV_LANES; l++) begin
        trial = {1'b0, NUM_W'(ln_in[l].den)} << K;
        if ({1'b0, ln_in[l].rem} >= trial) begin
          lane_nxt[l].rem    = ln_in[l].rem - trial[NUM_W-1:0];
          lane_nxt[l].quo[K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else if (en) begin
        valid_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[s] <= sd_in;
        lane_r[s] <= lane_nxt;
      end
    end
  end

  assign out_valid = valid_r[QUO_W-1];
  assign out_side  = side_r[QUO_W-1];
  assign out_lanes = lane_r[QUO_W-1];

endmodule

`default_nettype wire

// ===== rtl/core/uvs_cordic.sv =====
`default_nettype none

module uvs_cordic (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        en,
  input  wire logic                                        in_valid,
  input  wire uvs_pkg::ctx_t                               in_ctx,
  input  wire logic [uvs_pkg::ANGLE_BITS-1:0]              in_lat,
  input  wire logic [uvs_pkg::ANGLE_BITS-1:0]              in_lon,
  output logic                                             out_valid,
  output uvs_pkg::ctx_t                                    out_ctx,
  output uvs_pkg::cord_lane_t [uvs_pkg::CORD_LANES-1:0]    out_lanes
);
  import uvs_pkg::*;

  logic                       prep_valid_r;
  ctx_t                       prep_ctx_r;
  cord_lane_t [CORD_LANES-1:0] prep_lane_r;
  cord_lane_t [CORD_LANES-1:0] prep_lane_nxt;
  logic [ANGLE_BITS-1:0]      ang [CORD_LANES];

  logic                        valid_r [CORDIC_STEPS];
  ctx_t                        ctx_r   [CORDIC_STEPS];
  cord_lane_t [CORD_LANES-1:0] lane_r  [CORDIC_STEPS];

  assign ang[CL_LAT] = in_lat;
  assign ang[CL_LON] = in_lon;

  always_comb begin
    logic [TURN_W-1:0] t;
    logic              fl;
    prep_lane_nxt = '0;
    for (int l = 0; l < CORD_LANES; l++) begin
      t  = {ang[l], (TURN_W - ANGLE_BITS)'(0)};
      fl = t[TURN_W-1] ^ t[TURN_W-2];
      t[TURN_W-1] = t[TURN_W-1] ^ fl;
      prep_lane_nxt[l].flip = fl;
      prep_lane_nxt[l].x    = CORDIC_GAIN;
      prep_lane_nxt[l].y    = '0;
      prep_lane_nxt[l].z    = {{(Z_W - TURN_W){t[TURN_W-1]}}, t};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_valid_r <= 1'b0;
    end else if (en) begin
      prep_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_ctx_r  <= in_ctx;
      prep_lane_r <= prep_lane_nxt;
    end
  end

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_stage
    logic                        v_in;
    ctx_t                        c_in;
    cord_lane_t [CORD_LANES-1:0] ln_in;
    cord_lane_t [CORD_LANES-1:0] lane_nxt;
    logic signed [XY_W-1:0]      dx;
    logic signed [XY_W-1:0]      dy;

    if (s == 0) begin : g_first
      assign v_in  = prep_valid_r;
      assign c_in  = prep_ctx_r;
      assign ln_in = prep_lane_r;
    end else begin : g_next
      assign v_in  = valid_r[s-1];
      assign c_in  = ctx_r[s-1];
      assign ln_in = lane_r[s-1];
    end

    always_comb begin
      lane_nxt = ln_in;
      dx       = '0;
      dy       = '0;
      for (int l = 0; l < CORD_LANES; l++) begin
        dx = ln_in[l].y >>> s;
        dy = ln_in[l].x >>> s;
        if (!ln_in[l].z[Z_W-1]) begin
          lane_nxt[l].x = ln_in[l].x - dx;
          lane_nxt[l].y = ln_in[l].y + dy;
          lane_nxt[l].z = ln_in[l].z - Z_W'(ATAN_TURN[s]);
        end else begin
          lane_nxt[l].x = ln_in[l].x + dx;
          lane_nxt[l].y = ln_in[l].y - dy;
          lane_nxt[l].z = ln_in[l].z + Z_W'(ATAN_TURN[s]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else if (en) begin
        valid_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctx_r[s]  <= c_in;
        lane_r[s] <= lane_nxt;
      end
    end
  end

  assign out_valid = valid_r[CORDIC_STEPS-1];
  assign out_ctx   = ctx_r[CORDIC_STEPS-1];
  assign out_lanes = lane_r[CORDIC_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/core/uvs_post.sv =====
`default_nettype none

module uvs_post (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     en,
  input  wire logic                                     in_valid,
  input  wire uvs_pkg::ctx_t                            in_ctx,
  input  wire uvs_pkg::cord_lane_t [uvs_pkg::CORD_LANES-1:0] in_lanes,
  output logic                                          out_valid,
  output uvs_pkg::out_t                                 out_data
);
  import uvs_pkg::*;

  logic               f_valid_r;
  ctx_t               f_ctx_r;
  logic signed [31:0] clat_r, slat_r, clon_r, slon_r;
  logic signed [XY_W-1:0] clat_nxt, slat_nxt, clon_nxt, slon_nxt;

  logic               m_valid_r;
  ctx_t               m_ctx_r;
  logic signed [63:0] px_r, py_r;
  logic signed [31:0] mz_r;

  logic               o_valid_r;
  out_t               o_data_r;
  out_t               o_data_nxt;

  assign clat_nxt = in_lanes[CL_LAT].flip ? -in_lanes[CL_LAT].x : in_lanes[CL_LAT].x;
  assign slat_nxt = in_lanes[CL_LAT].flip ? -in_lanes[CL_LAT].y : in_lanes[CL_LAT].y;
  assign clon_nxt = in_lanes[CL_LON].flip ? -in_lanes[CL_LON].x : in_lanes[CL_LON].x;
  assign slon_nxt = in_lanes[CL_LON].flip ? -in_lanes[CL_LON].y : in_lanes[CL_LON].y;

  always_comb begin
    logic signed [63:0] rx, ry, rz;
    rx = (px_r + (64'sd1 <<< 44)) >>> 45;
    ry = (py_r + (64'sd1 <<< 44)) >>> 45;
    rz = (64'(mz_r) + (64'sd1 <<< 14)) >>> 15;
    o_data_nxt = '0;
    if (m_ctx_r.side.pv) begin
      o_data_nxt.point_valid     = 1'b1;
      o_data_nxt.pos_x           = sat16(rx);
      o_data_nxt.pos_y           = sat16(ry);
      o_data_nxt.pos_z           = sat16(rz);
      o_data_nxt.tex_u           = m_ctx_r.tex_u;
      o_data_nxt.tex_v           = m_ctx_r.tex_v;
      o_data_nxt.vertex_index    = m_ctx_r.side.vidx;
      o_data_nxt.upper_tri_valid = m_ctx_r.side.up;
      o_data_nxt.lower_tri_valid = m_ctx_r.side.lo;
      if (m_ctx_r.side.up || m_ctx_r.side.lo) begin
        o_data_nxt.below_index = m_ctx_r.side.vidx + 16'(m_ctx_r.side.nc) + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
      m_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else if (en) begin
      f_valid_r <= in_valid;
      m_valid_r <= f_valid_r;
      o_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_ctx_r  <= in_ctx;
      clat_r   <= 32'(clat_nxt);
      slat_r   <= 32'(slat_nxt);
      clon_r   <= 32'(clon_nxt);
      slon_r   <= 32'(slon_nxt);
      m_ctx_r  <= f_ctx_r;
      px_r     <= clat_r * clon_r;
      py_r     <= clat_r * slon_r;
      mz_r     <= slat_r;
      o_data_r <= o_data_nxt;
    end
  end

  assign out_valid = o_valid_r;
  assign out_data  = o_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/uv_sphere_vertex_and_index_gen.sv =====
// UV sphere grid point generator.
// Input channel in_valid/in_stall/in_data carries one grid point (stack,
// sector) per word; output channel out_valid/out_stall/out_data returns one
// word per point: unit position (also the normal) in Q1.15, texture u/v in
// Q1.16, the vertex number, the below index and the two triangle flags.
// Points outside the grid return point_valid low and all fields zero.
// stack_count and sector_count are written through cfg_valid/cfg_ready with
// cfg_index 0 and 1; cfg_ready is always high. Write them only while idle.
// The pipeline has 17 restoring divider stages for u, v and the two
// angles, one angle fold stage, 28 CORDIC stages, then flip, multiply and
// round/saturate stages, the last being the output register.
// Throughput is one point per cycle unless the output stalls. When out_stall
// holds a valid output word the whole pipeline freezes and in_stall rises in
// the same cycle; nothing is dropped or repeated. Synchronous reset empties
// the pipeline and loads the counts with 18 stacks and 36 sectors.
`default_nettype none

module uv_sphere_vertex_and_index_gen (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire uvs_pkg::in_t                      in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output uvs_pkg::out_t                          out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [uvs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [uvs_pkg::FIELD_BITS-1:0]    cfg_wdata
);
  import uvs_pkg::*;

  logic [FIELD_BITS-1:0] stack_count_r, sector_count_r;
  logic                  en;

  logic [COUNT_BITS-1:0] ns, nc;
  logic [FIELD_BITS-1:0] ns8, nc8, st, se;
  logic [16:0]           vidx_w;
  logic                  tri_ok;
  side_t                 side_in;
  div_lane_t [DIV_LANES-1:0] lanes_in;

  logic                      dv_valid;
  side_t                     dv_side;
  div_lane_t [DIV_LANES-1:0] dv_lanes;
  ctx_t                      dv_ctx;
  logic [ANGLE_BITS-1:0]     lon_ang, lat_ang;

  logic                        cd_valid;
  ctx_t                        cd_ctx;
  cord_lane_t [CORD_LANES-1:0] cd_lanes;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stack_count_r  <= STACK_COUNT_RST;
      sector_count_r <= SECTOR_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STACK_COUNT:  stack_count_r  <= cfg_wdata;
        REG_SECTOR_COUNT: sector_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign ns  = eff_count(stack_count_r);
  assign nc  = eff_count(sector_count_r);
  assign ns8 = FIELD_BITS'(ns);
  assign nc8 = FIELD_BITS'(nc);
  assign st  = in_data.stack_index;
  assign se  = in_data.sector_index;

  assign vidx_w = 17'(st) * 17'({1'b0, nc} + (COUNT_BITS + 1)'(1)) + 17'(se);
  assign tri_ok = (st < ns8) && (se < nc8);

  always_comb begin
    side_in      = '0;
    side_in.pv   = (st <= ns8) && (se <= nc8);
    side_in.up   = tri_ok && (st != '0);
    side_in.lo   = tri_ok && (st != ns8 - FIELD_BITS'(1));
    side_in.vidx = vidx_w[15:0];
    side_in.nc   = nc;

    lanes_in = '0;
    lanes_in[LANE_U].rem   = (NUM_W'(se) << (TEX_FRAC + 1)) | NUM_W'(nc);
    lanes_in[LANE_U].den   = {nc, 1'b0};
    lanes_in[LANE_V].rem   = (NUM_W'(st) << (TEX_FRAC + 1)) | NUM_W'(ns);
    lanes_in[LANE_V].den   = {ns, 1'b0};
    lanes_in[LANE_LON].rem = (NUM_W'(se) << (ANGLE_BITS + 1)) | NUM_W'(nc);
    lanes_in[LANE_LON].den = {nc, 1'b0};
    lanes_in[LANE_LAT].rem = (NUM_W'(st) << ANGLE_BITS) | NUM_W'(ns);
    lanes_in[LANE_LAT].den = {ns, 1'b0};
  end

  uvs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_side   (side_in),
    .in_lanes  (lanes_in),
    .out_valid (dv_valid),
    .out_side  (dv_side),
    .out_lanes (dv_lanes)
  );

  always_comb begin
    dv_ctx       = '0;
    dv_ctx.side  = dv_side;
    dv_ctx.tex_u = dv_lanes[LANE_U].quo[TEX_W-1:0];
    dv_ctx.tex_v = dv_lanes[LANE_V].quo[TEX_W-1:0];
  end

  assign lon_ang = dv_lanes[LANE_LON].quo[ANGLE_BITS-1:0];
  assign lat_ang = ANGLE_BITS'(1 << (ANGLE_BITS - 2)) - dv_lanes[LANE_LAT].quo[ANGLE_BITS-1:0];

  uvs_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dv_valid),
    .in_ctx    (dv_ctx),
    .in_lat    (lat_ang),
    .in_lon    (lon_ang),
    .out_valid (cd_valid),
    .out_ctx   (cd_ctx),
    .out_lanes (cd_lanes)
  );

  uvs_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (cd_valid),
    .in_ctx    (cd_ctx),
    .in_lanes  (cd_lanes),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_empty_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.point_valid |->
      out_data.vertex_index == '0 && out_data.tex_u == '0 && out_data.tex_v == '0)
    else $error("point outside grid carries non-zero fields");

  a_tri_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.upper_tri_valid || out_data.lower_tri_valid) |->
      out_data.point_valid)
    else $error("triangle flagged for a point outside grid");

  a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.point_valid |->
      out_data.tex_u <= TEX_W'(1 << TEX_FRAC) && out_data.tex_v <= TEX_W'(1 << TEX_FRAC))
    else $error("texture coordinate above one");

endmodule

`default_nettype wire
